FILE: design/gph_pkg.sv
// Shared constants and types for the gamma pair histogrammer.
// No dependencies; imported by gph_front, gph_back and the core, but not by gph_queue.
package gph_pkg;

  localparam int OpW      = 2;
  localparam int SlotW    = 3;
  localparam int RawW     = 16;
  localparam int BinW     = 16;
  localparam int CountW   = 8;
  localparam int AxisRegW = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int ShiftW   = 8;
  localparam int ShiftEntries = 8;
  localparam int CmdKindW = 2;

  localparam logic [OpW-1:0] OP_EVENT = 2'd0;
  localparam logic [OpW-1:0] OP_READ  = 2'd1;
  localparam logic [OpW-1:0] OP_WRITE = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_X_BITS     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_BITS     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOTS      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_TBL  = 3'd3;

  localparam logic [AxisRegW-1:0] AXIS_BITS_RESET = 4'd8;
  localparam logic [AxisRegW-1:0] SLOTS_RESET     = 4'd8;

  typedef enum logic [CmdKindW-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_INC   = 2'd2
  } cmd_kind_e;

endpackage

FILE: design/gph_front.sv
// Front end: config registers, slot store, per-slot scaling and pair sequencer.
// Depends on gph_pkg; feeds bin commands into gph_queue.
module gph_front #(
  parameter int MAX_SLOTS     = 8,
  parameter int MAX_AXIS_BITS = 8,
  parameter int VALUE_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gph_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gph_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gph_pkg::OpW-1:0]         op_i,
  input  logic [gph_pkg::SlotW-1:0]       slot_i,
  input  logic [gph_pkg::RawW-1:0]        raw_value_i,
  input  logic                            value_valid_i,
  input  logic                            event_end_i,
  input  logic [gph_pkg::BinW-1:0]        bin_x_i,
  input  logic [gph_pkg::BinW-1:0]        bin_y_i,
  input  logic [gph_pkg::CountW-1:0]      write_count_i,
  input  logic                            hold_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output gph_pkg::cmd_kind_e              cmd_kind_o,
  output logic [2*MAX_AXIS_BITS-1:0]      cmd_addr_o,
  output logic [gph_pkg::CountW-1:0]      cmd_data_o,
  output logic                            cmd_err_o
);
  import gph_pkg::*;

  localparam int SW  = (VALUE_BITS < RawW) ? VALUE_BITS : RawW;
  localparam int MA  = MAX_AXIS_BITS;
  localparam int AW  = 2 * MA;
  localparam int RW  = SW + MA;
  localparam int SIW = $clog2(MAX_SLOTS);
  localparam int NW  = $clog2(MAX_SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_PAIR  = 2'd2;

  logic [1:0]          st_q, st_d;
  logic [AxisRegW-1:0] x_bits_q, y_bits_q, slots_q;
  logic [CfgDataW-1:0] shift_tbl_q;

  logic [SW-1:0]  vals_q [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] pres_q;
  logic [MA-1:0]  sx_q [MAX_SLOTS];
  logic [MA-1:0]  sy_q [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] fx_q, fy_q;
  logic [SIW-1:0] k_q, i_q, j_q;

  logic [AxisRegW-1:0] xb, yb;
  logic [NW-1:0]       n_eff;
  logic                in_fire, is_rw, is_evt, slot_ok, rw_err;
  logic [AW-1:0]       rw_addr, pair_addr;
  logic                pair_hit, pair_step, last_k, last_j, last_i, end_pairs;

  logic [AxisRegW-1:0] k_ext;
  logic [ShiftW-1:0]   sh;
  logic [ShiftW-1:0]   sh_neg;
  logic [SW-1:0]       v;
  logic [RW-1:0]       r;
  logic                r_ok, fit_x, fit_y;

  always_comb begin
    if (x_bits_q == '0) xb = AxisRegW'(1);
    else if (int'(x_bits_q) > MAX_AXIS_BITS) xb = AxisRegW'(MAX_AXIS_BITS);
    else xb = x_bits_q;
    if (y_bits_q == '0) yb = AxisRegW'(1);
    else if (int'(y_bits_q) > MAX_AXIS_BITS) yb = AxisRegW'(MAX_AXIS_BITS);
    else yb = y_bits_q;
    if (int'(slots_q) > MAX_SLOTS) n_eff = NW'(MAX_SLOTS);
    else n_eff = NW'(slots_q);
  end

  assign is_rw   = (op_i == OP_READ) || (op_i == OP_WRITE);
  assign is_evt  = (op_i == OP_EVENT);
  assign slot_ok = int'(slot_i) < MAX_SLOTS;
  assign in_ready_o = (st_q == ST_IDLE) && !hold_i && cmd_ready_i;
  assign in_fire = in_valid_i && in_ready_o;

  assign rw_err  = ((bin_x_i >> xb) != '0) || ((bin_y_i >> yb) != '0);
  assign rw_addr = (AW'(bin_y_i[MA-1:0]) << xb) | AW'(bin_x_i[MA-1:0]);

  // per-slot scaling, one slot a cycle
  assign k_ext = AxisRegW'(k_q);
  assign v     = vals_q[k_q];
  assign sh    = k_ext[3] ? '0 : shift_tbl_q[{k_ext[2:0], 3'b000} +: ShiftW];
  assign sh_neg = ~sh + ShiftW'(1);

  always_comb begin
    r    = '0;
    r_ok = 1'b1;
    if (!sh[ShiftW-1]) begin
      r = RW'(v) >> sh[ShiftW-2:0];
    end else if (v == '0) begin
      r = '0;
    end else if (sh_neg >= ShiftW'(MAX_AXIS_BITS)) begin
      r_ok = 1'b0;
    end else begin
      r = RW'(v) << sh_neg;
    end
  end

  assign fit_x = pres_q[k_q] && r_ok && ((r >> xb) == '0);
  assign fit_y = pres_q[k_q] && r_ok && ((r >> yb) == '0);
  assign last_k = (NW'(k_q) + NW'(1)) == n_eff;

  assign pair_hit  = fx_q[i_q] && fy_q[j_q];
  assign pair_addr = (AW'(sy_q[j_q]) << xb) | AW'(sx_q[i_q]);
  assign pair_step = (st_q == ST_PAIR) && (!pair_hit || cmd_ready_i);
  assign last_j    = (NW'(j_q) + NW'(1)) == n_eff;
  assign last_i    = (NW'(i_q) + NW'(2)) == n_eff;
  assign end_pairs = pair_step && last_j && last_i;

  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_kind_o  = CMD_INC;
    cmd_addr_o  = pair_addr;
    cmd_data_o  = write_count_i;
    cmd_err_o   = 1'b0;
    if (st_q == ST_PAIR) begin
      cmd_valid_o = pair_hit;
    end else if (st_q == ST_IDLE) begin
      cmd_valid_o = in_valid_i && !hold_i && is_rw;
      cmd_kind_o  = (op_i == OP_WRITE) ? CMD_WRITE : CMD_READ;
      cmd_addr_o  = rw_addr;
      cmd_err_o   = rw_err;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire && is_evt && event_end_i && n_eff >= NW'(2)) st_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (last_k) st_d = ST_PAIR;
      end
      ST_PAIR: begin
        if (end_pairs) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      x_bits_q    <= AXIS_BITS_RESET;
      y_bits_q    <= AXIS_BITS_RESET;
      slots_q     <= SLOTS_RESET;
      shift_tbl_q <= '0;
      pres_q      <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_X_BITS:    x_bits_q    <= cfg_data_i[AxisRegW-1:0];
          CFG_Y_BITS:    y_bits_q    <= cfg_data_i[AxisRegW-1:0];
          CFG_SLOTS:     slots_q     <= cfg_data_i[AxisRegW-1:0];
          CFG_SHIFT_TBL: shift_tbl_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire && is_evt) begin
        if (event_end_i && n_eff < NW'(2)) pres_q <= '0;
        else if (slot_ok) pres_q[SIW'(slot_i)] <= value_valid_i;
        k_q <= '0;
      end
      if (st_q == ST_SCALE) begin
        k_q <= k_q + SIW'(1);
        i_q <= '0;
        j_q <= SIW'(1);
      end
      if (pair_step) begin
        if (last_j) begin
          i_q <= i_q + SIW'(1);
          j_q <= SIW'(i_q + SIW'(2));
        end else begin
          j_q <= j_q + SIW'(1);
        end
      end
      if (end_pairs) pres_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_evt && slot_ok) vals_q[SIW'(slot_i)] <= raw_value_i[SW-1:0];
    if (st_q == ST_SCALE) begin
      sx_q[k_q] <= r[MA-1:0];
      sy_q[k_q] <= r[MA-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= '0;
      fy_q <= '0;
    end else if (st_q == ST_SCALE) begin
      fx_q[k_q] <= fit_x;
      fy_q[k_q] <= fit_y;
    end
  end

endmodule

FILE: design/gph_queue.sv
// Short command queue between the front end and the histogram back end.
// Generic; no package dependency.
module gph_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (int'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
      if (pop)  rd_q <= (int'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
      if (push && !pop) cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

FILE: design/gph_back.sv
// Back end: counter memory with clearing pass, read-modify-write and result register.
// Depends on gph_pkg; takes commands from gph_queue.
module gph_back #(
  parameter int MAX_AXIS_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  gph_pkg::cmd_kind_e          cmd_kind_i,
  input  logic [2*MAX_AXIS_BITS-1:0]  cmd_addr_i,
  input  logic [gph_pkg::CountW-1:0]  cmd_data_i,
  input  logic                        cmd_err_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gph_pkg::CountW-1:0]  bin_count_o,
  output logic                        index_error_o
);
  import gph_pkg::*;

  localparam int AW    = 2 * MAX_AXIS_BITS;
  localparam int DEPTH = 1 << AW;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_RD   = 2'd1;
  localparam logic [1:0] BK_INC  = 2'd2;

  logic [CountW-1:0] mem [DEPTH];
  logic [CountW-1:0] rd_q, cnt_q;
  logic [AW-1:0]     clr_addr_q, addr_q, waddr;
  logic              clr_q, err_q, out_valid_q;
  logic [1:0]        st_q;
  logic              out_free, pop, we, res_set;
  logic [CountW-1:0] wdata;

  assign busy_o        = clr_q;
  assign out_valid_o   = out_valid_q;
  assign bin_count_o   = cnt_q;
  assign index_error_o = err_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = !clr_q && (st_q == BK_IDLE) && ((cmd_kind_i == CMD_INC) || out_free);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign res_set     = (st_q == BK_RD) ||
                       (pop && ((cmd_kind_i == CMD_WRITE) ||
                                ((cmd_kind_i == CMD_READ) && cmd_err_i)));

  always_comb begin
    we    = 1'b0;
    waddr = cmd_addr_i;
    wdata = cmd_data_i;
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else if (st_q == BK_INC) begin
      we    = 1'b1;
      waddr = addr_q;
      wdata = rd_q + CountW'(1);
    end else if (pop && cmd_kind_i == CMD_WRITE && !cmd_err_i) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[cmd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      st_q        <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == '1) clr_q <= 1'b0;
      end
      if (res_set) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (st_q)
        BK_IDLE: begin
          if (pop) begin
            case (cmd_kind_i)
              CMD_INC: st_q <= BK_INC;
              CMD_READ: begin
                if (!cmd_err_i) st_q <= BK_RD;
              end
              default: ;
            endcase
          end
        end
        BK_RD: st_q <= BK_IDLE;
        BK_INC: st_q <= BK_IDLE;
        default: st_q <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cmd_kind_i != CMD_INC) begin
      cnt_q <= '0;
      err_q <= cmd_err_i;
      addr_q <= cmd_addr_i;
    end else if (pop) begin
      addr_q <= cmd_addr_i;
    end
    if (st_q == BK_RD) begin
      cnt_q <= rd_q;
      err_q <= 1'b0;
    end
  end

endmodule

FILE: design/gamma_pair_histogrammer_core.sv
// End of event: the front end scales each slot, then steps through every slot pair,
// stalling on a hit while the queue is full; the back end does each counter increment as
// a memory read-modify-write and takes no command until the write. A read result passes
// the queue, the registered memory read and the result register, a write result the
// queue and the result register. Reset clears control state, then a clearing pass zeroes
// all 2^(2*MAX_AXIS_BITS) counters (65536 by default), one a cycle; no item is taken until it ends.
module gamma_pair_histogrammer_core #(
  parameter int MAX_SLOTS     = 8,
  parameter int MAX_AXIS_BITS = 8,
  parameter int VALUE_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gph_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gph_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gph_pkg::OpW-1:0]      op_i,
  input  logic [gph_pkg::SlotW-1:0]    slot_i,
  input  logic [gph_pkg::RawW-1:0]     raw_value_i,
  input  logic                         value_valid_i,
  input  logic                         event_end_i,
  input  logic [gph_pkg::BinW-1:0]     bin_x_i,
  input  logic [gph_pkg::BinW-1:0]     bin_y_i,
  input  logic [gph_pkg::CountW-1:0]   write_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gph_pkg::CountW-1:0]   bin_count_o,
  output logic                         index_error_o
);
  import gph_pkg::*;

  localparam int AW = 2 * MAX_AXIS_BITS;
  localparam int QW = CmdKindW + AW + CountW + 1;

  logic              f_valid, f_ready, b_valid, b_ready, busy;
  cmd_kind_e         f_kind;
  logic [AW-1:0]     f_addr;
  logic [CountW-1:0] f_data;
  logic              f_err;
  logic [QW-1:0]     q_in, q_out;

  gph_front #(
    .MAX_SLOTS     (MAX_SLOTS),
    .MAX_AXIS_BITS (MAX_AXIS_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .slot_i        (slot_i),
    .raw_value_i   (raw_value_i),
    .value_valid_i (value_valid_i),
    .event_end_i   (event_end_i),
    .bin_x_i       (bin_x_i),
    .bin_y_i       (bin_y_i),
    .write_count_i (write_count_i),
    .hold_i        (busy),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready),
    .cmd_kind_o    (f_kind),
    .cmd_addr_o    (f_addr),
    .cmd_data_o    (f_data),
    .cmd_err_o     (f_err)
  );

  assign q_in = {f_kind, f_addr, f_data, f_err};

  gph_queue #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  gph_back #(
    .MAX_AXIS_BITS (MAX_AXIS_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (b_valid),
    .cmd_ready_o   (b_ready),
    .cmd_kind_i    (cmd_kind_e'(q_out[QW-1 -: CmdKindW])),
    .cmd_addr_i    (q_out[CountW+1 +: AW]),
    .cmd_data_i    (q_out[1 +: CountW]),
    .cmd_err_i     (q_out[0]),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bin_count_o   (bin_count_o),
    .index_error_o (index_error_o)
  );

endmodule
